[rtl/dcpn_pkg.sv]
package dcpn_pkg;

	localparam int PACKET_BYTES   = 16;
	localparam int RESPONSE_BYTES = 16;

	localparam int PKT_AW = $clog2(PACKET_BYTES);
	// count must also hold the overlong mark PACKET_BYTES + 1
	localparam int PKT_CW = $clog2(PACKET_BYTES + 2);
	localparam int RSP_AW = $clog2(RESPONSE_BYTES);
	localparam int RSP_CW = $clog2(RESPONSE_BYTES + 1);

	localparam logic [PKT_CW-1:0] PKT_FULL = PKT_CW'(PACKET_BYTES);
	localparam logic [PKT_CW-1:0] PKT_OVER = PKT_CW'(PACKET_BYTES + 1);
	localparam logic [RSP_CW-1:0] RSP_FULL = RSP_CW'(RESPONSE_BYTES);

	// packet lengths, header and footer included
	localparam logic [PKT_CW-1:0] LEN_MIN     = PKT_CW'(3);
	localparam logic [PKT_CW-1:0] LEN_NO_ARG  = PKT_CW'(3);
	localparam logic [PKT_CW-1:0] LEN_ONE_ARG = PKT_CW'(4);
	localparam logic [PKT_CW-1:0] LEN_TWO_ARG = PKT_CW'(5);
	localparam logic [PKT_CW-1:0] RSP_LEN_PLAIN = PKT_CW'(5);
	localparam logic [PKT_CW-1:0] RSP_LEN_ECHO  = PKT_CW'(7);

	// positions inside a stored packet
	localparam logic [PKT_CW-1:0] POS_HDR  = PKT_CW'(0);
	localparam logic [PKT_CW-1:0] POS_CMD  = PKT_CW'(1);
	localparam logic [PKT_CW-1:0] POS_ARG1 = PKT_CW'(2);
	localparam logic [PKT_CW-1:0] POS_ARG2 = PKT_CW'(3);

	// positions inside a response
	localparam logic [PKT_CW-1:0] RSP_POS_HDR    = PKT_CW'(0);
	localparam logic [PKT_CW-1:0] RSP_POS_STATUS = PKT_CW'(1);
	localparam logic [PKT_CW-1:0] RSP_POS_ADDR   = PKT_CW'(2);
	localparam logic [PKT_CW-1:0] RSP_POS_CMD    = PKT_CW'(3);
	localparam logic [PKT_CW-1:0] RSP_POS_ECHO1  = PKT_CW'(4);

	localparam logic [7:0] BCAST_HDR = 8'h80;
	localparam logic [7:0] RSP_HDR   = 8'hBF;
	localparam logic [7:0] RSP_FTR   = 8'hCF;
	localparam logic [7:0] ST_OK     = 8'hFE;
	localparam logic [7:0] ST_FAIL   = 8'hFF;

	localparam logic [7:0] CMD_STOP      = 8'h01;
	localparam logic [7:0] CMD_READDR    = 8'h02;
	localparam logic [7:0] CMD_POUR      = 8'h40;
	localparam logic [7:0] CMD_POUR_PWM  = 8'h41;
	localparam logic [7:0] CMD_REV_TIME  = 8'h42;
	localparam logic [7:0] CMD_REV_PWM   = 8'h43;
	localparam logic [7:0] CMD_LIGHT_OFF = 8'h44;

	localparam logic [2:0] ACT_STOP      = 3'd0;
	localparam logic [2:0] ACT_POUR_PWM  = 3'd1;
	localparam logic [2:0] ACT_REV_PWM   = 3'd2;
	localparam logic [2:0] ACT_REV_TIME  = 3'd3;
	localparam logic [2:0] ACT_POUR      = 3'd4;
	localparam logic [2:0] ACT_LIGHT_OFF = 3'd5;
	localparam logic [2:0] ACT_LIGHT_ON  = 3'd6;
	localparam logic [2:0] ACT_READDR    = 3'd7;

	localparam logic KIND_TX  = 1'b0;
	localparam logic KIND_ACT = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic [2:0] action;
		logic [6:0] arg_first;
		logic [6:0] arg_second;
		logic       last;
	} result_t;

endpackage

[rtl/dcpn_ifs.sv]
interface dcpn_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface dcpn_tx_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] tx_byte;
	logic [2:0] action;
	logic [6:0] arg_first;
	logic [6:0] arg_second;
	logic       last;

	modport source (output valid, output kind, output tx_byte, output action,
		output arg_first, output arg_second, output last, input ready);
	modport sink (input valid, input kind, input tx_byte, input action,
		input arg_first, input arg_second, input last, output ready);
endinterface

[rtl/dcpn_byte_ram.sv]
module dcpn_byte_ram #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/dcpn_out_reg.sv]
module dcpn_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              emit,
	input  dcpn_pkg::result_t res,
	output logic              out_free,
	dcpn_tx_if.source         tx
);

	logic              valid_q;
	dcpn_pkg::result_t data_q;

	assign out_free = !valid_q || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= res;
		end
	end

	assign tx.valid      = valid_q;
	assign tx.kind       = data_q.kind;
	assign tx.tx_byte    = data_q.tx_byte;
	assign tx.action     = data_q.action;
	assign tx.arg_first  = data_q.arg_first;
	assign tx.arg_second = data_q.arg_second;
	assign tx.last       = data_q.last;

endmodule

[rtl/dcpn_ctrl.sv]
module dcpn_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	dcpn_rx_if.sink                       rx,
	input  logic                          out_free,
	output logic                          emit,
	output dcpn_pkg::result_t             res,
	output logic                          pkt_we,
	output logic [dcpn_pkg::PKT_AW-1:0]   pkt_waddr,
	output logic [7:0]                    pkt_wdata,
	output logic [dcpn_pkg::PKT_AW-1:0]   pkt_raddr,
	input  logic [7:0]                    pkt_rdata,
	output logic                          held_we,
	output logic [dcpn_pkg::RSP_AW-1:0]   held_waddr,
	output logic [7:0]                    held_wdata,
	output logic [dcpn_pkg::RSP_AW-1:0]   held_raddr,
	input  logic [7:0]                    held_rdata
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_PASS    = 3'd1;
	localparam logic [2:0] S_PROC    = 3'd2;
	localparam logic [2:0] S_HOLD_RD = 3'd3;
	localparam logic [2:0] S_HOLD_WR = 3'd4;
	localparam logic [2:0] S_REL_RD  = 3'd5;
	localparam logic [2:0] S_REL_OUT = 3'd6;

	typedef struct packed {
		logic       ok;
		logic       bcast;
		logic       echo;
		logic       readdr;
		logic       act_emit;
		logic [2:0] action;
		logic [6:0] a1;
		logic [6:0] a2;
	} dec_t;

	function automatic dec_t decode(input logic [7:0] cmd, input logic [7:0] hdr,
		input logic [7:0] arg1, input logic [7:0] arg2,
		input logic [dcpn_pkg::PKT_CW-1:0] cnt);
		dec_t d;
		logic over;
		logic unknown;
		d = '0;
		unknown = 1'b0;
		over = cnt > dcpn_pkg::PKT_FULL;
		d.bcast = (hdr == dcpn_pkg::BCAST_HDR) && !over;
		if (!over) begin
			unique case (cmd)
				dcpn_pkg::CMD_STOP: begin
					d.ok = cnt == dcpn_pkg::LEN_NO_ARG;
					d.action = dcpn_pkg::ACT_STOP;
				end
				dcpn_pkg::CMD_POUR_PWM: begin
					d.ok = cnt == dcpn_pkg::LEN_ONE_ARG;
					d.action = dcpn_pkg::ACT_POUR_PWM;
					d.a1 = arg1[6:0];
				end
				dcpn_pkg::CMD_REV_PWM: begin
					d.ok = cnt == dcpn_pkg::LEN_ONE_ARG;
					d.action = dcpn_pkg::ACT_REV_PWM;
					d.a1 = arg1[6:0];
				end
				dcpn_pkg::CMD_REV_TIME: begin
					d.ok = cnt == dcpn_pkg::LEN_TWO_ARG;
					d.action = dcpn_pkg::ACT_REV_TIME;
					d.a1 = arg1[6:0];
					d.a2 = arg2[6:0];
				end
				dcpn_pkg::CMD_POUR: begin
					d.ok = cnt == dcpn_pkg::LEN_TWO_ARG;
					d.action = dcpn_pkg::ACT_POUR;
					d.a1 = arg1[6:0];
					d.a2 = arg2[6:0];
					d.echo = d.ok;
				end
				dcpn_pkg::CMD_LIGHT_OFF: begin
					d.ok = cnt == dcpn_pkg::LEN_NO_ARG;
					d.action = dcpn_pkg::ACT_LIGHT_OFF;
				end
				dcpn_pkg::CMD_READDR: begin
					d.ok = cnt == dcpn_pkg::LEN_ONE_ARG;
					d.action = dcpn_pkg::ACT_READDR;
					d.a1 = arg1[6:0];
					d.readdr = d.ok;
				end
				default: begin
					// unknown command: light on, always answered
					unknown = 1'b1;
					d.bcast = 1'b0;
					d.action = dcpn_pkg::ACT_LIGHT_ON;
				end
			endcase
		end
		d.act_emit = unknown || d.ok;
		return d;
	endfunction

	logic [2:0]                    state_q, state_d;
	logic                          receiving_q, receiving_d;
	logic [dcpn_pkg::PKT_CW-1:0]   cnt_q, cnt_d;
	logic [6:0]                    node_q, node_d;
	logic                          po_q, po_d;
	logic [dcpn_pkg::RSP_CW-1:0]   held_q, held_d;
	logic [dcpn_pkg::RSP_CW-1:0]   ridx_q, ridx_d;

	logic [7:0]                    byte_q, byte_d;
	logic [7:0]                    hdr_q, hdr_d;
	logic [7:0]                    cmd_q, cmd_d;
	logic [7:0]                    arg1_q, arg1_d;
	logic [7:0]                    arg2_q, arg2_d;
	logic                          ok_q, ok_d;
	logic                          bcast_q, bcast_d;
	logic                          readdr_q, readdr_d;
	logic [dcpn_pkg::PKT_CW-1:0]   hidx_q, hidx_d;
	logic [dcpn_pkg::PKT_CW-1:0]   hlen_q, hlen_d;

	logic                          store_en;
	logic                          store_first;
	logic [dcpn_pkg::PKT_CW-1:0]   sidx;
	logic                          hdr_match;
	logic                          rel_now;
	logic [7:0]                    hold_byte;
	dec_t                          dec;

	assign rx.ready  = state_q == S_IDLE;
	assign hdr_match = ({1'b0, rx.rx_byte[5:0]} == node_q) || (rx.rx_byte[5:0] == 6'd0);
	assign rel_now   = !po_q && (held_q != '0);
	assign dec       = decode(cmd_q, hdr_q, arg1_q, arg2_q, cnt_q);
	assign pkt_raddr  = hidx_q[dcpn_pkg::PKT_AW-1:0];
	assign held_raddr = ridx_q[dcpn_pkg::RSP_AW-1:0];
	assign sidx = store_first ? dcpn_pkg::POS_HDR : cnt_q;

	// next byte for the held queue: forwarded packet or built response
	always_comb begin
		if (bcast_q) begin
			if (hidx_q == dcpn_pkg::POS_ARG1 && readdr_q) begin
				hold_byte = {1'b0, node_q + 7'd1};
			end else begin
				hold_byte = pkt_rdata;
			end
		end else if (hidx_q == hlen_q - dcpn_pkg::PKT_CW'(1)) begin
			hold_byte = dcpn_pkg::RSP_FTR;
		end else begin
			unique case (hidx_q)
				dcpn_pkg::RSP_POS_HDR:    hold_byte = dcpn_pkg::RSP_HDR;
				dcpn_pkg::RSP_POS_STATUS: hold_byte = ok_q ? dcpn_pkg::ST_OK : dcpn_pkg::ST_FAIL;
				dcpn_pkg::RSP_POS_ADDR:   hold_byte = {1'b0, node_q};
				dcpn_pkg::RSP_POS_CMD:    hold_byte = cmd_q;
				dcpn_pkg::RSP_POS_ECHO1:  hold_byte = arg1_q;
				default:                  hold_byte = arg2_q;
			endcase
		end
	end

	always_comb begin
		state_d     = state_q;
		receiving_d = receiving_q;
		cnt_d       = cnt_q;
		node_d      = node_q;
		po_d        = po_q;
		held_d      = held_q;
		ridx_d      = ridx_q;
		byte_d      = byte_q;
		hdr_d       = hdr_q;
		cmd_d       = cmd_q;
		arg1_d      = arg1_q;
		arg2_d      = arg2_q;
		ok_d        = ok_q;
		bcast_d     = bcast_q;
		readdr_d    = readdr_q;
		hidx_d      = hidx_q;
		hlen_d      = hlen_q;
		store_en    = 1'b0;
		store_first = 1'b0;
		emit        = 1'b0;
		res         = '0;
		pkt_we      = 1'b0;
		pkt_waddr   = sidx[dcpn_pkg::PKT_AW-1:0];
		pkt_wdata   = rx.rx_byte;
		held_we     = 1'b0;
		held_waddr  = held_q[dcpn_pkg::RSP_AW-1:0];
		held_wdata  = hold_byte;

		unique case (state_q)
			S_IDLE: begin
				if (rx.valid) begin
					byte_d = rx.rx_byte;
					if (rx.rx_byte[7]) begin
						if (rx.rx_byte[6]) begin
							if (receiving_q) begin
								store_en    = 1'b1;
								receiving_d = 1'b0;
								state_d     = S_PROC;
							end else begin
								po_d    = 1'b0;
								state_d = S_PASS;
							end
						end else if (hdr_match) begin
							// restart the packet at its header
							store_en    = 1'b1;
							store_first = 1'b1;
							receiving_d = 1'b1;
						end else begin
							po_d    = 1'b1;
							state_d = S_PASS;
						end
					end else if (receiving_q) begin
						store_en = 1'b1;
					end else begin
						state_d = S_PASS;
					end
					if (state_d == S_IDLE && !po_d && held_q != '0) begin
						state_d = S_REL_RD;
					end
				end
			end
			S_PASS: begin
				if (out_free) begin
					emit        = 1'b1;
					res.kind    = dcpn_pkg::KIND_TX;
					res.tx_byte = byte_q;
					res.last    = !rel_now;
					state_d     = rel_now ? S_REL_RD : S_IDLE;
				end
			end
			S_PROC: begin
				if (cnt_q < dcpn_pkg::LEN_MIN) begin
					state_d = rel_now ? S_REL_RD : S_IDLE;
				end else if (!dec.act_emit || out_free) begin
					emit           = dec.act_emit;
					res.kind       = dcpn_pkg::KIND_ACT;
					res.action     = dec.action;
					res.arg_first  = dec.a1;
					res.arg_second = dec.a2;
					// queue is never empty after this, so release follows unless held back
					res.last       = po_q;
					ok_d     = dec.ok;
					bcast_d  = dec.bcast;
					readdr_d = dec.readdr;
					if (dec.readdr) begin
						node_d = dec.a1;
					end
					hidx_d = '0;
					if (dec.bcast) begin
						hlen_d = cnt_q;
					end else begin
						hlen_d = dec.echo ? dcpn_pkg::RSP_LEN_ECHO : dcpn_pkg::RSP_LEN_PLAIN;
					end
					state_d = S_HOLD_RD;
				end
			end
			S_HOLD_RD: begin
				state_d = S_HOLD_WR;
			end
			S_HOLD_WR: begin
				// drop bytes once the queue is full
				if (held_q < dcpn_pkg::RSP_FULL) begin
					held_we = 1'b1;
					held_d  = held_q + dcpn_pkg::RSP_CW'(1);
				end
				hidx_d = hidx_q + dcpn_pkg::PKT_CW'(1);
				if (hidx_q == hlen_q - dcpn_pkg::PKT_CW'(1)) begin
					state_d = (!po_q && held_d != '0) ? S_REL_RD : S_IDLE;
				end else begin
					state_d = S_HOLD_RD;
				end
			end
			S_REL_RD: begin
				state_d = S_REL_OUT;
			end
			S_REL_OUT: begin
				if (out_free) begin
					emit        = 1'b1;
					res.kind    = dcpn_pkg::KIND_TX;
					res.tx_byte = held_rdata;
					res.last    = ridx_q == held_q - dcpn_pkg::RSP_CW'(1);
					if (res.last) begin
						held_d  = '0;
						ridx_d  = '0;
						state_d = S_IDLE;
					end else begin
						ridx_d  = ridx_q + dcpn_pkg::RSP_CW'(1);
						state_d = S_REL_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (store_en) begin
			if (sidx < dcpn_pkg::PKT_FULL) begin
				pkt_we = 1'b1;
				cnt_d  = sidx + dcpn_pkg::PKT_CW'(1);
				unique case (sidx)
					dcpn_pkg::POS_HDR:  hdr_d  = rx.rx_byte;
					dcpn_pkg::POS_CMD:  cmd_d  = rx.rx_byte;
					dcpn_pkg::POS_ARG1: arg1_d = rx.rx_byte;
					dcpn_pkg::POS_ARG2: arg2_d = rx.rx_byte;
					default: ;
				endcase
			end else begin
				cnt_d = dcpn_pkg::PKT_OVER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			receiving_q <= 1'b0;
			cnt_q       <= '0;
			node_q      <= '0;
			po_q        <= 1'b0;
			held_q      <= '0;
			ridx_q      <= '0;
		end else begin
			state_q     <= state_d;
			receiving_q <= receiving_d;
			cnt_q       <= cnt_d;
			node_q      <= node_d;
			po_q        <= po_d;
			held_q      <= held_d;
			ridx_q      <= ridx_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q   <= byte_d;
		hdr_q    <= hdr_d;
		cmd_q    <= cmd_d;
		arg1_q   <= arg1_d;
		arg2_q   <= arg2_d;
		ok_q     <= ok_d;
		bcast_q  <= bcast_d;
		readdr_q <= readdr_d;
		hidx_q   <= hidx_d;
		hlen_q   <= hlen_d;
	end

`ifndef SYNTH
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result emitted while output register is busy");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= dcpn_pkg::RSP_FULL)
		else $error("held queue count out of range");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dcpn_pkg::PKT_OVER)
		else $error("packet byte count out of range");

	a_no_stale: assert property (@(posedge clk) disable iff (!arst_n)
		rx.ready |-> (po_q || held_q == '0))
		else $error("idle with releasable bytes still held");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REL_OUT && emit && res.last) |=> (held_q == '0 && state_q == S_IDLE))
		else $error("held queue not cleared after release");
`endif

endmodule

[rtl/daisy_chain_packet_node.sv]
// Channel | Dir | Payload                                              | Beat when
// rx      | in  | rx_byte[7:0]                                         | valid && ready
// tx      | out | kind, tx_byte, action, arg_first, arg_second, last   | valid && ready
//
// One sequencer moves one byte per step through the packet store, the held queue and a
// single output register. A stored byte is written in the idle step, a passed-through byte
// is sent from a pass step; a footer that closes a stored packet runs a process step, a read
// and a write step per queued byte, then a read and an output step per released byte, the
// read steps set by the registered read of each store. Reset clears control state at once;
// the stores need no clearing pass. rx.ready is high only in the idle step, so it is low from
// a beat that leaves idle until the sequencer returns; a stalled tx holds it in its emitting step.
module daisy_chain_packet_node (
	input  logic      clk,
	input  logic      arst_n,
	dcpn_rx_if.sink   rx,
	dcpn_tx_if.source tx
);

	logic                          emit;
	logic                          out_free;
	dcpn_pkg::result_t             res;
	logic                          pkt_we;
	logic [dcpn_pkg::PKT_AW-1:0]   pkt_waddr;
	logic [7:0]                    pkt_wdata;
	logic [dcpn_pkg::PKT_AW-1:0]   pkt_raddr;
	logic [7:0]                    pkt_rdata;
	logic                          held_we;
	logic [dcpn_pkg::RSP_AW-1:0]   held_waddr;
	logic [7:0]                    held_wdata;
	logic [dcpn_pkg::RSP_AW-1:0]   held_raddr;
	logic [7:0]                    held_rdata;

	dcpn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.out_free   (out_free),
		.emit       (emit),
		.res        (res),
		.pkt_we     (pkt_we),
		.pkt_waddr  (pkt_waddr),
		.pkt_wdata  (pkt_wdata),
		.pkt_raddr  (pkt_raddr),
		.pkt_rdata  (pkt_rdata),
		.held_we    (held_we),
		.held_waddr (held_waddr),
		.held_wdata (held_wdata),
		.held_raddr (held_raddr),
		.held_rdata (held_rdata)
	);

	dcpn_byte_ram #(
		.DEPTH (dcpn_pkg::PACKET_BYTES)
	) u_pkt_ram (
		.clk   (clk),
		.we    (pkt_we),
		.waddr (pkt_waddr),
		.wdata (pkt_wdata),
		.raddr (pkt_raddr),
		.rdata (pkt_rdata)
	);

	dcpn_byte_ram #(
		.DEPTH (dcpn_pkg::RESPONSE_BYTES)
	) u_held_ram (
		.clk   (clk),
		.we    (held_we),
		.waddr (held_waddr),
		.wdata (held_wdata),
		.raddr (held_raddr),
		.rdata (held_rdata)
	);

	dcpn_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.res      (res),
		.out_free (out_free),
		.tx       (tx)
	);

endmodule
